@@ hw/rtl/tak_pkg.sv @@
`timescale 1ns / 1ps

package tak_pkg;

  // Widths fixed by the sample and result formats.
  localparam int FIELD_W            = 16;
  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int SQ_W               = 2 * FIELD_W;
  localparam int ENERGY_W           = 34;
  localparam int CMP_W              = FIELD_W + 2;
  localparam int TILT_THR_W         = 15;
  localparam int HOLD_W             = 8;
  localparam int FLAGS_W            = 4;
  localparam int CFG_INDEX_W        = 2;
  localparam int CFG_DATA_W         = ENERGY_W;
  localparam int FIFO_DEPTH_DEFAULT = 4;

  // Register values after reset.
  localparam logic [TILT_THR_W-1:0] TILT_THRESHOLD_RESET  = TILT_THR_W'(2500);
  localparam logic [ENERGY_W-1:0]   KNOCK_THRESHOLD_RESET = ENERGY_W'(50000000);
  localparam logic [HOLD_W-1:0]     KNOCK_HOLD_RESET      = HOLD_W'(10);
  localparam logic [HOLD_W-1:0]     HOLD_MAX              = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TILT_THRESHOLD  = 2'd0,
    REG_KNOCK_THRESHOLD = 2'd1,
    REG_KNOCK_HOLD      = 2'd2
  } cfg_reg_t;

  // One classified sample on its way from the front end to the knock tracker.
  typedef struct packed {
    logic               primed;
    logic [FLAGS_W-1:0] tilt_flags;
    logic [SQ_W-1:0]    sq_x;
    logic [SQ_W-1:0]    sq_y;
    logic [SQ_W-1:0]    sq_z;
  } tak_entry_t;

  // Knock tracker status, watched at the top level.
  typedef struct packed {
    logic              active;
    logic [HOLD_W-1:0] hold;
    logic              knock_start;
  } tak_status_t;

endpackage

@@ hw/rtl/tilt_and_knock_detector_top.sv @@
`timescale 1ns / 1ps

// Tilt and knock detector. Each request on the slave stream is one signed
// three-axis accelerometer sample and yields exactly one result on the master
// stream: a 4-bit tilt code for x and y against tilt_threshold, and a knock
// bit that is set on the sample that starts a knock, that is, when the
// squared-distance energy of the change from the previous sample reaches
// knock_threshold outside a knock. A knock ends once the energy is below the
// threshold and the sample count since it began exceeds knock_hold. The first
// sample after reset only primes the previous sample, so its knock bit is 0.
// The block takes one sample per clock cycle; a sample passes the input
// register with the three squarers, then the queue, then the knock state
// update with the output register. A stalled output fills the queue first,
// and the input stalls only once the queue and the input register are full.
// Write the configuration registers only while no sample is in flight.
module tilt_and_knock_detector_top #(
  parameter int SAMPLE_BITS = tak_pkg::SAMPLE_BITS_DEFAULT,
  parameter int FIFO_DEPTH  = tak_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tak_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tak_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // From bit 0: accel_x[15:0], accel_y[31:16], accel_z[47:32].
  input  logic [47:0]                       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // From bit 0: tilt_flags[3:0], knock_event[4], zero fill [7:5].
  output logic [7:0]                        m_axis_tdata
);
  import tak_pkg::*;

  logic [TILT_THR_W-1:0] tilt_threshold;
  logic [ENERGY_W-1:0]   knock_threshold;
  logic [HOLD_W-1:0]     knock_hold;

  logic                  push_valid;
  logic                  push_ready;
  tak_entry_t            push_entry;
  logic                  pop_valid;
  logic                  pop_ready;
  tak_entry_t            pop_entry;
  logic [FLAGS_W-1:0]    out_tilt_flags;
  logic                  out_knock_event;
  tak_status_t           status;

  // Configuration registers. Writes to an index past the last register are
  // dropped, and wider data is cut to the register width.
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_threshold  <= TILT_THRESHOLD_RESET;
      knock_threshold <= KNOCK_THRESHOLD_RESET;
      knock_hold      <= KNOCK_HOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TILT_THRESHOLD: begin
          tilt_threshold <= cfg_data[TILT_THR_W-1:0];
        end
        REG_KNOCK_THRESHOLD: begin
          knock_threshold <= cfg_data[ENERGY_W-1:0];
        end
        REG_KNOCK_HOLD: begin
          knock_hold <= cfg_data[HOLD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front end: classifies tilt and squares the per-axis change.
  tak_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .tilt_threshold(tilt_threshold),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .accel_x       (s_axis_tdata[15:0]),
    .accel_y       (s_axis_tdata[31:16]),
    .accel_z       (s_axis_tdata[47:32]),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  // Short queue so that output stalls do not reach back to the input at once.
  tak_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry)
  );

  // Back end: sums the energy and runs the knock state.
  tak_back u_back (
    .clk            (clk),
    .rst            (rst),
    .knock_threshold(knock_threshold),
    .knock_hold     (knock_hold),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_entry      (pop_entry),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_tilt_flags (out_tilt_flags),
    .out_knock_event(out_knock_event),
    .status         (status)
  );

  assign m_axis_tdata = {3'b000, out_knock_event, out_tilt_flags};

  // A knock that starts is active on the next cycle.
  a_start_sets_active: assert property (@(posedge clk) disable iff (rst)
    status.knock_start |=> status.active)
    else $error("knock start did not set the active state");

  // A knock ends only once the hold count has passed the hold time.
  a_end_after_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(status.active)) |-> (status.hold > knock_hold))
    else $error("knock ended before the hold time");

  // The cycle after reset nothing is waiting in the queue or at the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !pop_valid))
    else $error("pipeline not empty after reset");

endmodule

@@ hw/rtl/tak_front.sv @@
`timescale 1ns / 1ps

module tak_front #(
  parameter int SAMPLE_BITS = tak_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [tak_pkg::TILT_THR_W-1:0]   tilt_threshold,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tak_pkg::FIELD_W-1:0]      accel_x,
  input  logic [tak_pkg::FIELD_W-1:0]      accel_y,
  input  logic [tak_pkg::FIELD_W-1:0]      accel_z,
  output logic                             push_valid,
  input  logic                             push_ready,
  output tak_pkg::tak_entry_t              push_entry
);
  import tak_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = 2 * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] last_x;
  logic [SAMPLE_BITS-1:0] last_y;
  logic [SAMPLE_BITS-1:0] last_z;
  logic                   primed;
  logic                   s1_valid;
  tak_entry_t             s1_entry;
  tak_entry_t             entry_next;
  logic                   in_fire;

  // Squared difference of two samples; the magnitude of the difference
  // always fits in SAMPLE_BITS unsigned bits.
  function automatic logic [SQ_W-1:0] square_diff(input logic [SAMPLE_BITS-1:0] a,
                                                  input logic [SAMPLE_BITS-1:0] b);
    logic [DIFF_W-1:0] d;
    logic [PROD_W-1:0] m;
    d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
    m = d[DIFF_W-1] ? PROD_W'(SAMPLE_BITS'(-d)) : PROD_W'(d[SAMPLE_BITS-1:0]);
    return SQ_W'(m * m);
  endfunction

  // Returns {below minus threshold, above threshold}.
  function automatic logic [1:0] tilt_pair(input logic [SAMPLE_BITS-1:0] v,
                                           input logic [TILT_THR_W-1:0] thr);
    logic signed [CMP_W-1:0] vc;
    logic signed [CMP_W-1:0] tc;
    vc = CMP_W'(signed'(v));
    tc = signed'(CMP_W'(thr));
    return {(vc < -tc), (vc > tc)};
  endfunction

  assign in_fire    = in_valid && in_ready;
  assign in_ready   = !s1_valid || push_ready;
  assign push_valid = s1_valid;
  assign push_entry = s1_entry;

  always_comb begin
    entry_next.primed     = primed;
    entry_next.tilt_flags = {tilt_pair(accel_y[SAMPLE_BITS-1:0], tilt_threshold),
                             tilt_pair(accel_x[SAMPLE_BITS-1:0], tilt_threshold)};
    entry_next.sq_x       = square_diff(accel_x[SAMPLE_BITS-1:0], last_x);
    entry_next.sq_y       = square_diff(accel_y[SAMPLE_BITS-1:0], last_y);
    entry_next.sq_z       = square_diff(accel_z[SAMPLE_BITS-1:0], last_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      primed   <= 1'b0;
      last_x   <= '0;
      last_y   <= '0;
      last_z   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        primed   <= 1'b1;
        last_x   <= accel_x[SAMPLE_BITS-1:0];
        last_y   <= accel_y[SAMPLE_BITS-1:0];
        last_z   <= accel_z[SAMPLE_BITS-1:0];
      end else if (push_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_entry <= entry_next;
    end
  end

endmodule

@@ hw/rtl/tak_fifo.sv @@
`timescale 1ns / 1ps

module tak_fifo #(
  parameter int DEPTH = tak_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  tak_pkg::tak_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tak_pkg::tak_entry_t pop_entry
);
  import tak_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tak_entry_t         entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push_fire;
  logic               pop_fire;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop_fire) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ hw/rtl/tak_back.sv @@
`timescale 1ns / 1ps

module tak_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tak_pkg::ENERGY_W-1:0]    knock_threshold,
  input  logic [tak_pkg::HOLD_W-1:0]      knock_hold,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  tak_pkg::tak_entry_t             pop_entry,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tak_pkg::FLAGS_W-1:0]     out_tilt_flags,
  output logic                            out_knock_event,
  output tak_pkg::tak_status_t            status
);
  import tak_pkg::*;

  logic                active;
  logic [HOLD_W-1:0]   hold;
  logic                active_next;
  logic [HOLD_W-1:0]   hold_next;
  logic                start_next;
  logic [ENERGY_W-1:0] energy;
  logic                above;
  logic                pop_fire;

  assign pop_ready = !out_valid || out_ready;
  assign pop_fire  = pop_valid && pop_ready;

  assign energy = ENERGY_W'(pop_entry.sq_x) + ENERGY_W'(pop_entry.sq_y)
                + ENERGY_W'(pop_entry.sq_z);
  assign above  = (energy >= knock_threshold);

  always_comb begin
    active_next = active;
    hold_next   = hold;
    start_next  = 1'b0;
    if (pop_entry.primed) begin
      if (!active) begin
        if (above) begin
          active_next = 1'b1;
          hold_next   = '0;
          start_next  = 1'b1;
        end
      end else begin
        if (hold != HOLD_MAX) begin
          hold_next = hold + HOLD_W'(1);
        end
        if (!above && (hold_next > knock_hold)) begin
          active_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      hold      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop_fire) begin
        active    <= active_next;
        hold      <= hold_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      out_tilt_flags  <= pop_entry.tilt_flags;
      out_knock_event <= start_next;
    end
  end

  assign status.active      = active;
  assign status.hold        = hold;
  assign status.knock_start = pop_fire && start_next;

endmodule
